// ===== hdl/hrcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrcc_pkg
// Shared types, codes and constants of the HTTP request completeness checker.
// ----------------------------------------------------------------------------
package hrcc_pkg;

	localparam int unsigned HDR_W   = 21;
	localparam int unsigned BODY_W  = 31;
	localparam int unsigned CNT_W   = 33;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned KW_LEN  = 15;

	localparam logic [HDR_W-1:0]  HDR_SAT    = '1;
	localparam logic [CNT_W-1:0]  CNT_SAT    = '1;
	localparam logic [ACC_W-1:0]  NEG_LIMIT  = 32'h8000_0000;
	localparam logic [ACC_W-1:0]  POS_LIMIT  = 32'h7FFF_FFFF;

	localparam logic [HDR_W-1:0]  MAX_HDR_RST  = 21'd8192;
	localparam logic [BODY_W-1:0] MAX_BODY_RST = 31'd4194304;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_HEADER = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_BODY   = 2'd1;

	// Verdict codes
	typedef logic [2:0] status_t;
	localparam status_t ST_INCOMPLETE = 3'd0;
	localparam status_t ST_COMPLETE   = 3'd1;
	localparam status_t ST_HDR_LARGE  = 3'd2;
	localparam status_t ST_BODY_LARGE = 3'd3;
	localparam status_t ST_MALFORMED  = 3'd4;

	// Content-Length value parser phases
	typedef logic [2:0] phase_t;
	localparam phase_t PH_NONE   = 3'd0;
	localparam phase_t PH_LEAD   = 3'd1;
	localparam phase_t PH_SIGN   = 3'd2;
	localparam phase_t PH_DIGITS = 3'd3;
	localparam phase_t PH_VALID  = 3'd4;
	localparam phase_t PH_BAD    = 3'd5;

	// Terminator search progress
	typedef logic [2:0] term_t;
	localparam term_t TM_IDLE = 3'd0;
	localparam term_t TM_CR1  = 3'd1;
	localparam term_t TM_LF1  = 3'd2;
	localparam term_t TM_CR2  = 3'd3;
	localparam term_t TM_DONE = 3'd4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_C     = 8'h43;

	typedef struct packed {
		logic [HDR_W-1:0]  max_header_bytes;
		logic [BODY_W-1:0] max_body_bytes;
	} limits_t;

	typedef struct packed {
		status_t           status;
		logic [HDR_W-1:0]  header_length;
		logic [BODY_W-1:0] body_length;
	} result_t;

	// "Content-Length:"
	function automatic logic [7:0] kw_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hrcc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrcc_in_if
// Request byte channel: one raw byte per transaction.
// ----------------------------------------------------------------------------
interface hrcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/hrcc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrcc_out_if
// Verdict channel: one verdict per request byte.
// ----------------------------------------------------------------------------
interface hrcc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [20:0] header_length;
	logic [30:0] body_length;

	modport source (output valid, output status, output header_length,
		output body_length, input ready);
	modport sink   (input valid, input status, input header_length,
		input body_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/hrcc_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrcc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hrcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [30:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/hrcc_state.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrcc_state
// Per-request state: header terminator search, Content-Length keyword match
// and value parse, byte count and sticky verdict. One byte per step.
// ----------------------------------------------------------------------------
module hrcc_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  hrcc_pkg::limits_t limits,
	output hrcc_pkg::result_t res
);
	import hrcc_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	term_t             tp_q;
	logic              hd_q;
	logic [HDR_W-1:0]  hb_q;
	logic [3:0]        kp_q;
	phase_t            ph_q;
	logic              pcr_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic              ovf_q;
	status_t           sticky_q;

	logic [CNT_W-1:0]  cnt_n;
	term_t             tp_n;
	logic              hd_n;
	logic [HDR_W-1:0]  hb_n;
	logic [3:0]        kp_n;
	phase_t            ph_n;
	logic              pcr_n;
	logic              neg_n;
	logic [ACC_W-1:0]  acc_n;
	logic              ovf_n;
	status_t           sticky_n;

	logic              is_dig;
	logic              is_blank;
	logic [3:0]        dig;
	logic [35:0]       acc_x10;
	logic [CNT_W-1:0]  need;

	function automatic phase_t finish(input phase_t ph, input logic ovf, input logic neg,
		input logic [ACC_W-1:0] acc);
		phase_t r;
		r = ph;
		if (ph == PH_DIGITS) begin
			r = (ovf || (!neg && acc > POS_LIMIT)) ? PH_BAD : PH_VALID;
		end else if (ph == PH_LEAD || ph == PH_SIGN) begin
			r = PH_BAD;
		end
		return r;
	endfunction

	assign is_dig   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
		(data_byte == CH_LF) || (data_byte == CH_VT) || (data_byte == CH_FF);
	assign dig      = 4'(data_byte - CH_ZERO);

	always_comb begin
		cnt_n    = first_byte ? '0 : cnt_q;
		tp_n     = first_byte ? TM_IDLE : tp_q;
		hd_n     = first_byte ? 1'b0 : hd_q;
		hb_n     = first_byte ? '0 : hb_q;
		kp_n     = first_byte ? '0 : kp_q;
		ph_n     = first_byte ? PH_NONE : ph_q;
		pcr_n    = first_byte ? 1'b0 : pcr_q;
		neg_n    = first_byte ? 1'b0 : neg_q;
		acc_n    = first_byte ? '0 : acc_q;
		ovf_n    = first_byte ? 1'b0 : ovf_q;
		sticky_n = first_byte ? ST_INCOMPLETE : sticky_q;
		acc_x10  = {acc_n, 3'b000} + {3'b000, acc_n, 1'b0} + 36'(dig);
		need     = '0;

		if (sticky_n == ST_INCOMPLETE) begin
			if (cnt_n != CNT_SAT) begin
				cnt_n = cnt_n + 1'b1;
			end
			if (!hd_n) begin
				case (ph_n)
					PH_NONE: begin
						if (data_byte == kw_char(kp_n)) begin
							kp_n = kp_n + 1'b1;
						end else begin
							kp_n = (data_byte == CH_C) ? 4'd1 : 4'd0;
						end
						if (kp_n >= 4'(KW_LEN)) begin
							kp_n = '0;
							ph_n = PH_LEAD;
						end
					end
					PH_LEAD: begin
						if (pcr_n && data_byte == CH_LF) begin
							pcr_n = 1'b0;
							ph_n  = PH_BAD;
						end else begin
							pcr_n = 1'b0;
							if (data_byte == CH_CR) begin
								pcr_n = 1'b1;
							end else if (is_blank) begin
								ph_n = PH_LEAD;
							end else if (data_byte == CH_PLUS) begin
								ph_n = PH_SIGN;
							end else if (data_byte == CH_MINUS) begin
								neg_n = 1'b1;
								ph_n  = PH_SIGN;
							end else if (is_dig) begin
								acc_n = 32'(dig);
								ph_n  = PH_DIGITS;
							end else begin
								ph_n = PH_BAD;
							end
						end
					end
					PH_SIGN: begin
						if (is_dig) begin
							acc_n = 32'(dig);
							ph_n  = PH_DIGITS;
						end else begin
							ph_n = PH_BAD;
						end
					end
					PH_DIGITS: begin
						if (is_dig) begin
							if (acc_x10 > 36'(NEG_LIMIT)) begin
								ovf_n = 1'b1;
							end else begin
								acc_n = acc_x10[ACC_W-1:0];
							end
						end else begin
							ph_n = finish(ph_n, ovf_n, neg_n, acc_n);
						end
					end
					default: begin
						ph_n = ph_n;
					end
				endcase

				if (data_byte == CH_CR) begin
					tp_n = (tp_n == TM_LF1) ? TM_CR2 : TM_CR1;
				end else if (data_byte == CH_LF && tp_n == TM_CR1) begin
					tp_n = TM_LF1;
				end else if (data_byte == CH_LF && tp_n == TM_CR2) begin
					tp_n = TM_DONE;
				end else begin
					tp_n = TM_IDLE;
				end
				if (tp_n == TM_DONE) begin
					hd_n = 1'b1;
					hb_n = (cnt_n > CNT_W'(HDR_SAT)) ? HDR_SAT : cnt_n[HDR_W-1:0];
				end
			end

			// acc is never changed by the byte that ends the header
			need = CNT_W'(hb_n) + CNT_W'(acc_n);
			if (!hd_n) begin
				sticky_n = (cnt_n > CNT_W'(limits.max_header_bytes)) ? ST_HDR_LARGE
					: ST_INCOMPLETE;
			end else if (hb_n > limits.max_header_bytes) begin
				sticky_n = ST_HDR_LARGE;
			end else if (ph_n == PH_NONE) begin
				sticky_n = ST_COMPLETE;
			end else begin
				ph_n = finish(ph_n, ovf_n, neg_n, acc_n);
				if (ph_n != PH_VALID) begin
					sticky_n = ST_MALFORMED;
				end else if (neg_n && acc_n != '0) begin
					sticky_n = ST_BODY_LARGE;
				end else if (acc_n > ACC_W'(limits.max_body_bytes)) begin
					sticky_n = ST_BODY_LARGE;
				end else if (cnt_n >= need) begin
					sticky_n = ST_COMPLETE;
				end else begin
					sticky_n = ST_INCOMPLETE;
				end
			end
		end

		res.status        = sticky_n;
		res.header_length = hd_n ? hb_n : '0;
		res.body_length   = (ph_n == PH_VALID && !(neg_n && acc_n != '0))
			? acc_n[BODY_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tp_q     <= TM_IDLE;
			hd_q     <= 1'b0;
			hb_q     <= '0;
			kp_q     <= '0;
			ph_q     <= PH_NONE;
			pcr_q    <= 1'b0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			sticky_q <= ST_INCOMPLETE;
		end else if (step) begin
			cnt_q    <= cnt_n;
			tp_q     <= tp_n;
			hd_q     <= hd_n;
			hb_q     <= hb_n;
			kp_q     <= kp_n;
			ph_q     <= ph_n;
			pcr_q    <= pcr_n;
			neg_q    <= neg_n;
			acc_q    <= acc_n;
			ovf_q    <= ovf_n;
			sticky_q <= sticky_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ST_INCOMPLETE && !(step && first_byte)) |=> $stable(sticky_q))
		else $error("terminal verdict changed without a new request");

	a_complete_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q == ST_COMPLETE) |-> hd_q)
		else $error("complete verdict before header end");

	a_keyword_range: assert property (@(posedge clk) disable iff (!arst_n)
		kp_q < 4'(KW_LEN))
		else $error("keyword progress out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/http_request_completeness_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_completeness_checker
// Checks an HTTP request byte stream for header end and declared body length,
// giving a verdict after every byte.
// ----------------------------------------------------------------------------
// A byte goes from the input register to the verdict output register.
// Throughput: one byte per cycle unless the verdict output stalls; the
// state update is a single pass through the byte logic between the input
// register and the verdict register. Reset: clears both pipeline stages and
// all request state; limits return to 8192 header bytes and 4194304 body bytes.
module http_request_completeness_checker (
	input  logic       clk,
	input  logic       arst_n,
	hrcc_in_if.sink    byte_ch,
	hrcc_out_if.source verdict_ch,
	hrcc_cfg_if.sink   cfg
);
	import hrcc_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       out_v_q;
	result_t    out_q;
	limits_t    limits_q;
	result_t    res;
	logic       step;

	assign step         = v_s1 && (!out_v_q || verdict_ch.ready);
	assign byte_ch.ready = !v_s1 || step;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (byte_ch.ready) begin
				v_s1 <= byte_ch.valid;
			end
			if (step) begin
				out_v_q <= 1'b1;
			end else if (verdict_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1  <= byte_ch.data_byte;
			first_s1 <= byte_ch.first_byte;
		end
		if (step) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_header_bytes <= MAX_HDR_RST;
			limits_q.max_body_bytes   <= MAX_BODY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MAX_HEADER: limits_q.max_header_bytes <= cfg.data[HDR_W-1:0];
				REG_MAX_BODY:   limits_q.max_body_bytes   <= cfg.data;
				default:        limits_q <= limits_q;
			endcase
		end
	end

	hrcc_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.limits     (limits_q),
		.res        (res)
	);

	assign verdict_ch.valid         = out_v_q;
	assign verdict_ch.status        = out_q.status;
	assign verdict_ch.header_length = out_q.header_length;
	assign verdict_ch.body_length   = out_q.body_length;

`ifndef NO_ASSERTIONS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> byte_ch.ready)
		else $error("input stalled with empty output register");

	a_verdict_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !verdict_ch.ready) |=> (out_v_q && $stable(out_q)))
		else $error("verdict changed while stalled");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !byte_ch.ready) |=> (v_s1 && $stable(byte_s1) && $stable(first_s1)))
		else $error("held byte changed while stalled");
`endif

endmodule
`default_nettype wire
